FILE: rtl/core/lsds_pkg.sv
package lsds_pkg;

  localparam int WIN_W  = 13;
  localparam int ROWS_W = 7;
  localparam int SUM_W  = 46;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [1:0] ACT_LOAD_X  = 2'd0;
  localparam logic [1:0] ACT_LOAD_Y  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 4'd1;

  typedef enum logic [1:0] {
    OP_LOAD_X,
    OP_LOAD_Y,
    OP_COMPUTE
  } op_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic [11:0]        x_lag;
    logic [11:0]        y_lag;
  } in_t;

  typedef struct packed {
    logic [5:0]       row_index;
    logic [SUM_W-1:0] diff_sum;
    logic             range_error;
    logic             last;
  } out_t;

  typedef struct packed {
    op_t                op;
    logic               addr_ok;
    logic [11:0]        addr;
    logic signed [15:0] value;
    logic [11:0]        x_lag;
    logic [11:0]        y_lag;
    logic [ROWS_W-1:0]  rows;
    logic               err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/lsds_front.sv
module lsds_front #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_ROWS    = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  lsds_pkg::in_t                in_data,
  input  logic [lsds_pkg::WIN_W-1:0]   window_len,
  input  logic [lsds_pkg::ROWS_W-1:0]  rows_in_use,
  input  lsds_pkg::q_stat_t            q_stat,
  output logic                         push,
  output lsds_pkg::cmd_t               push_cmd
);
  import lsds_pkg::*;

  localparam int SPAN_W = WIN_W + ROWS_W;
  localparam logic [SPAN_W:0] DEPTH_C = (SPAN_W + 1)'(STORE_DEPTH);
  localparam logic [ROWS_W-1:0] ROWS_MAX_C = ROWS_W'(MAX_ROWS);

  logic              fv_r, fv_nxt;
  cmd_t              fcmd_r, fcmd_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [ROWS_W-1:0] rows_c;
  logic              take;
  logic              err_c;

  always_comb begin
    if (rows_in_use == '0) begin
      rows_c = ROWS_W'(1);
    end else if (rows_in_use > ROWS_MAX_C) begin
      rows_c = ROWS_MAX_C;
    end else begin
      rows_c = rows_in_use;
    end
  end

  assign busy = fv_r && q_stat.full;
  assign push = fv_r && !q_stat.full;
  assign take = start && !busy;

  assign err_c = ((SPAN_W + 1)'(fcmd_r.x_lag) + (SPAN_W + 1)'(span_r) > DEPTH_C) ||
                 ((SPAN_W + 1)'(fcmd_r.y_lag) + (SPAN_W + 1)'(span_r) > DEPTH_C);

  always_comb begin
    push_cmd     = fcmd_r;
    push_cmd.err = err_c;
  end

  always_comb begin
    fv_nxt   = fv_r && q_stat.full;
    fcmd_nxt = fcmd_r;
    span_nxt = span_r;
    if (take) begin
      fv_nxt = (in_data.action == ACT_LOAD_X) || (in_data.action == ACT_LOAD_Y) ||
               (in_data.action == ACT_COMPUTE);
      unique case (in_data.action)
        ACT_LOAD_X: fcmd_nxt.op = OP_LOAD_X;
        ACT_LOAD_Y: fcmd_nxt.op = OP_LOAD_Y;
        default:    fcmd_nxt.op = OP_COMPUTE;
      endcase
      fcmd_nxt.addr_ok = (SPAN_W + 1)'(in_data.sample_addr) < DEPTH_C;
      fcmd_nxt.addr    = in_data.sample_addr;
      fcmd_nxt.value   = in_data.sample_value;
      fcmd_nxt.x_lag   = in_data.x_lag;
      fcmd_nxt.y_lag   = in_data.y_lag;
      fcmd_nxt.rows    = rows_c;
      fcmd_nxt.err     = 1'b0;
      span_nxt         = SPAN_W'(rows_c) * SPAN_W'(window_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fcmd_r <= fcmd_nxt;
    span_r <= span_nxt;
  end

endmodule

FILE: rtl/core/lsds_queue.sv
module lsds_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lsds_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output lsds_pkg::cmd_t     head,
  output lsds_pkg::q_stat_t  q_stat
);
  import lsds_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign head         = slot_r[rp_r];
  assign q_stat.full  = cnt_r == (Q_AW + 1)'(Q_DEPTH);
  assign q_stat.empty = cnt_r == '0;

  always_comb begin
    wp_nxt  = push ? wp_r + Q_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + Q_AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (Q_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/lsds_back.sv
module lsds_back #(
  parameter int STORE_DEPTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lsds_pkg::cmd_t             head,
  input  lsds_pkg::q_stat_t          q_stat,
  output logic                       pop,
  input  logic [lsds_pkg::WIN_W-1:0] window_len,
  output logic                       out_valid,
  output lsds_pkg::out_t             out_data
);
  import lsds_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
  localparam int DW = SAMPLE_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = ((PW > SUM_W) ? PW : SUM_W) + 1;
  localparam logic signed [CW-1:0] S_HI = CW'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [CW-1:0] S_LO = CW'(-(1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } st_t;

  typedef struct packed {
    logic       has_sample;
    logic       row_end;
    logic       err;
    logic       last;
    logic [5:0] row_index;
  } tok_t;

  logic signed [SAMPLE_BITS-1:0] x_mem [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] y_mem [STORE_DEPTH];

  st_t              st_r, st_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [AW-1:0]    x_ptr_r, x_ptr_nxt;
  logic [AW-1:0]    y_ptr_r, y_ptr_nxt;
  logic [5:0]       row_r, row_nxt;
  logic [WIN_W-1:0] smp_r, smp_nxt;

  logic                          t1_v_r, t2_v_r;
  tok_t                          t1_r, t2_r, tok_c;
  logic signed [SAMPLE_BITS-1:0] xq_r, yq_r;
  logic [PW-1:0]                 sq_r;
  logic [SUM_W-1:0]              acc_r, acc_nxt;
  logic                          out_valid_r;
  out_t                          out_r, out_nxt;

  logic signed [CW-1:0]          v_ext;
  logic signed [CW-1:0]          v_clip;
  logic signed [SAMPLE_BITS-1:0] wr_val;
  logic                          issue;
  logic signed [DW-1:0]          d_c;
  logic signed [PW-1:0]          prod_c;
  logic [SW-1:0]                 sum_c;
  logic [SUM_W-1:0]              sat_c;
  logic [SUM_W-1:0]              sel_c;

  assign v_ext  = CW'($signed(head.value));
  assign v_clip = (v_ext > S_HI) ? S_HI : ((v_ext < S_LO) ? S_LO : v_ext);
  assign wr_val = v_clip[SAMPLE_BITS-1:0];

  assign pop   = (st_r == S_IDLE) && !q_stat.empty;
  assign issue = (st_r == S_RUN);

  always_comb begin
    tok_c.has_sample = !cur_r.err && (window_len != '0);
    tok_c.row_end    = !tok_c.has_sample || (smp_r == window_len - WIN_W'(1));
    tok_c.err        = cur_r.err;
    tok_c.last       = ROWS_W'(row_r) == cur_r.rows - ROWS_W'(1);
    tok_c.row_index  = row_r;
  end

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    x_ptr_nxt = x_ptr_r;
    y_ptr_nxt = y_ptr_r;
    row_nxt   = row_r;
    smp_nxt   = smp_r;
    unique case (st_r)
      S_IDLE: begin
        if (pop && (head.op == OP_COMPUTE)) begin
          cur_nxt   = head;
          x_ptr_nxt = AW'(head.x_lag);
          y_ptr_nxt = AW'(head.y_lag);
          row_nxt   = '0;
          smp_nxt   = '0;
          st_nxt    = S_RUN;
        end
      end
      S_RUN: begin
        if (tok_c.has_sample) begin
          x_ptr_nxt = x_ptr_r + AW'(1);
          y_ptr_nxt = y_ptr_r + AW'(1);
          smp_nxt   = tok_c.row_end ? '0 : smp_r + WIN_W'(1);
        end
        if (tok_c.row_end) begin
          row_nxt = row_r + 6'd1;
          if (tok_c.last) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign d_c    = DW'(xq_r) - DW'(yq_r);
  assign prod_c = d_c * d_c;
  assign sum_c  = SW'(acc_r) + SW'(sq_r);
  assign sat_c  = (sum_c > SW'(SUM_MAX)) ? SUM_MAX : sum_c[SUM_W-1:0];
  assign sel_c  = t2_r.has_sample ? sat_c : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (t2_v_r) begin
      acc_nxt = t2_r.row_end ? '0 : sel_c;
    end
    out_nxt.row_index   = t2_r.row_index;
    out_nxt.diff_sum    = sel_c;
    out_nxt.range_error = t2_r.err;
    out_nxt.last        = t2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      t1_v_r      <= 1'b0;
      t2_v_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      t1_v_r      <= issue;
      t2_v_r      <= t1_v_r;
      acc_r       <= acc_nxt;
      out_valid_r <= t2_v_r && t2_r.row_end;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    x_ptr_r <= x_ptr_nxt;
    y_ptr_r <= y_ptr_nxt;
    row_r   <= row_nxt;
    smp_r   <= smp_nxt;
    t1_r    <= tok_c;
    t2_r    <= t1_r;
    sq_r    <= $unsigned(prod_c);
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == OP_LOAD_X) && head.addr_ok) begin
      x_mem[AW'(head.addr)] <= wr_val;
    end
    xq_r <= x_mem[x_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == OP_LOAD_Y) && head.addr_ok) begin
      y_mem[AW'(head.addr)] <= wr_val;
    end
    yq_r <= y_mem[y_ptr_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/lagged_squared_difference_sums.sv
// Lagged squared-difference sums over two sample stores, X and Y.
// Input channel: an item is taken on a rising edge with start high and busy
// low. Action 0 or 1 writes sample_value into X or Y at sample_addr; action 2
// carries a lag pair and yields rows_in_use results, one per row; action 3
// is dropped. Results appear on out_data for one cycle with out_valid high;
// the receiver must take each one, it cannot stall the block.
// Configuration: write window_len (index 0) or rows_in_use (index 1) through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only while
// the block is idle.
// Structure: a front stage registers and classifies each item, a four-entry
// queue decouples it from the back end. The back end takes one queued item at
// a time: a lag pair runs as rows_in_use * window_len sample steps (one step
// per row when the window is empty or out of range) through its single
// multiply-accumulate path and one read port per store, and the next item is
// popped only after the last row is issued. A rows_in_use of 0 counts as 1 and
// one above MAX_ROWS counts as MAX_ROWS.
// busy rises while the front stage waits on a full queue.
// Reset: config returns to window_len 1, rows_in_use 1; queued and running
// items are dropped. Stores are not cleared: read only written entries.
module lagged_squared_difference_sums #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_ROWS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  lsds_pkg::in_t                    in_data,
  output logic                             out_valid,
  output lsds_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsds_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsds_pkg::*;

  logic [WIN_W-1:0]  window_len_r, window_len_nxt;
  logic [ROWS_W-1:0] rows_in_use_r, rows_in_use_nxt;
  logic              push, pop;
  cmd_t              push_cmd, head;
  q_stat_t           q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    window_len_nxt  = window_len_r;
    rows_in_use_nxt = rows_in_use_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN:  window_len_nxt  = cfg_data[WIN_W-1:0];
        CFG_ROWS_IN_USE: rows_in_use_nxt = cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= WIN_W'(1);
      rows_in_use_r <= ROWS_W'(1);
    end else begin
      window_len_r  <= window_len_nxt;
      rows_in_use_r <= rows_in_use_nxt;
    end
  end

  lsds_front #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .window_len (window_len_r),
    .rows_in_use(rows_in_use_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lsds_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  lsds_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .window_len(window_len_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> out_data.diff_sum == '0)
    else $error("range error result with nonzero sum");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_stat.full && !push)
    else $error("busy without a full queue");

endmodule

FILE: bench/tb_lagged_squared_difference_sums.sv
`timescale 1ns / 100ps

module tb_lagged_squared_difference_sums;
  import lsds_pkg::*;

  localparam int DEPTH        = 4096;
  localparam int ROW_CAP      = 64;
  localparam int FILL         = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 12;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_t                   item;
    logic                  fixed;
    logic [SUM_W-1:0]      sum;
    logic                  err;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic signed [15:0] x_mirror [DEPTH];
  logic signed [15:0] y_mirror [DEPTH];
  logic [WIN_W-1:0]   mirror_win;
  logic [ROWS_W-1:0]  mirror_rows;
  out_t               pending_rows [$];
  step_t              directed [$];
  bit                 steady;
  int                 n_items;
  int                 n_pairs;
  int                 n_checked;
  int                 n_writes;
  int                 n_errors;

  always #4 clk = ~clk;

  lagged_squared_difference_sums i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic step_t step_load(input logic [1:0] act, input logic [11:0] addr,
                                      input logic [15:0] val);
    step_t s;
    s = '0;
    s.item.action = act;
    s.item.sample_addr = addr;
    s.item.sample_value = val;
    s.item.x_lag = addr;
    s.item.y_lag = ~addr;
    return s;
  endfunction

  function automatic step_t step_pair(input logic [11:0] xl, input logic [11:0] yl,
                                      input logic fixed, input logic [SUM_W-1:0] sum,
                                      input logic err);
    step_t s;
    s = '0;
    s.item.action = ACT_COMPUTE;
    s.item.x_lag = xl;
    s.item.y_lag = yl;
    s.fixed = fixed;
    s.sum = sum;
    s.err = err;
    return s;
  endfunction

  function automatic step_t step_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic int unsigned active_rows();
    if (mirror_rows == 0) return 1;
    if (mirror_rows > ROW_CAP) return ROW_CAP;
    return mirror_rows;
  endfunction

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [11:0] err_lag(input int unsigned span);
    if (span > DEPTH) return 12'($urandom);
    return 12'($urandom_range(DEPTH - span + 1, DEPTH - 1));
  endfunction

  task automatic forecast_item(input in_t it, input logic fixed,
                               input logic [SUM_W-1:0] fsum, input logic ferr);
    int unsigned rows;
    int unsigned span;
    int unsigned xb;
    int unsigned yb;
    int unsigned k;
    int unsigned i;
    logic bad;
    longint d;
    longint unsigned acc;
    out_t want;
    case (it.action)
      ACT_LOAD_X: x_mirror[it.sample_addr] = it.sample_value;
      ACT_LOAD_Y: y_mirror[it.sample_addr] = it.sample_value;
      ACT_COMPUTE: begin
        rows = active_rows();
        span = rows * mirror_win;
        xb = it.x_lag;
        yb = it.y_lag;
        bad = (xb + span > DEPTH) || (yb + span > DEPTH);
        for (k = 0; k < rows; k++) begin
          acc = 0;
          if (!bad) begin
            for (i = 0; i < mirror_win; i++) begin
              d = longint'(x_mirror[xb + k * mirror_win + i])
                - longint'(y_mirror[yb + k * mirror_win + i]);
              acc += longint'(d * d);
            end
          end
          want.row_index = k[5:0];
          want.diff_sum = fixed ? fsum : acc[SUM_W-1:0];
          want.range_error = fixed ? ferr : bad;
          want.last = (k + 1 == rows);
          pending_rows.push_back(want);
        end
        n_pairs++;
      end
      default: ;
    endcase
    n_items++;
  endtask

  task automatic drive_item(input in_t it, input logic fixed,
                            input logic [SUM_W-1:0] fsum, input logic ferr);
    int gap;
    logic [63:0] junk;
    gap = idle_len();
    junk = {$urandom, $urandom};
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_data <= junk[$bits(in_t)-1:0];
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    forecast_item(it, fixed, fsum, ferr);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_WINDOW_LEN) mirror_win = val[WIN_W-1:0];
    else if (idx == CFG_ROWS_IN_USE) mirror_rows = val[ROWS_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int p);
    logic [WIN_W-1:0] win;
    logic [ROWS_W-1:0] rows;
    int unsigned r;
    int unsigned hi;
    int unsigned span;
    int counted;
    logic [63:0] junk;
    in_t it;
    if (p == 0) begin
      win = 13'd1;
      rows = 7'd16;
    end else if (p == 1) begin
      win = 13'd24;
      rows = 7'd1;
    end else begin
      r = $urandom_range(0, 19);
      if (r == 0) win = 13'd0;
      else if (r == 1) win = 13'($urandom_range(4097, 8191));
      else if (r == 2) win = 13'd4096;
      else if (r < 6) win = 13'($urandom_range(17, 256));
      else win = 13'($urandom_range(1, 8));
      r = $urandom_range(0, 19);
      if (r == 0) rows = 7'd0;
      else if (r == 1) rows = 7'($urandom_range(65, 127));
      else if (r == 2) rows = 7'(ROW_CAP);
      else if (r < 6) rows = 7'($urandom_range(9, 40));
      else rows = 7'($urandom_range(1, 4));
    end
    settle();
    hi = $urandom_range(0, 1) ? $urandom : 0;
    write_reg(CFG_WINDOW_LEN, {hi[2:0], win});
    hi = $urandom_range(0, 1) ? $urandom : 0;
    write_reg(CFG_ROWS_IN_USE, {hi[8:0], rows});
    write_reg(4'($urandom_range(2, 15)), 16'($urandom));
    steady = (p == 0);
    span = active_rows() * mirror_win;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      junk = {$urandom, $urandom};
      it = junk[$bits(in_t)-1:0];
      r = $urandom_range(0, 99);
      if (r < 12) begin
        it.action = ACT_UNUSED;
      end else if (r < 55) begin
        it.action = $urandom_range(0, 1) ? ACT_LOAD_Y : ACT_LOAD_X;
        if ($urandom_range(0, 1)) begin
          it.sample_addr = 12'($urandom_range(0, FILL - 1));
        end
        counted++;
      end else begin
        it.action = ACT_COMPUTE;
        r = $urandom_range(0, 3);
        if (span != 0) begin
          if (span <= FILL && (span < 2 || r != 0)) begin
            it.x_lag = 12'($urandom_range(0, FILL - span));
            it.y_lag = 12'($urandom_range(0, FILL - span));
          end else if (r[0]) begin
            it.x_lag = err_lag(span);
          end else begin
            it.y_lag = err_lag(span);
          end
        end
        counted++;
      end
      drive_item(it, 1'b0, '0, 1'b0);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_rows.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got row %0d sum %0d err %0b last %0b",
                 $time, out_data.row_index, out_data.diff_sum, out_data.range_error,
                 out_data.last);
      end else begin
        want = pending_rows.pop_front();
        n_checked++;
        if (out_data.row_index !== want.row_index || out_data.diff_sum !== want.diff_sum ||
            out_data.range_error !== want.range_error || out_data.last !== want.last) begin
          n_errors++;
          $display("%0t: mismatch, expected row %0d sum %0d err %0b last %0b",
                   $time, want.row_index, want.diff_sum, want.range_error, want.last);
          $display("%0t:           actual row %0d sum %0d err %0b last %0b",
                   $time, out_data.row_index, out_data.diff_sum, out_data.range_error,
                   out_data.last);
        end
      end
    end
  end

  initial begin : stimulus
    in_t it;
    int a;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mirror_win = 13'd1;
    mirror_rows = 7'd1;
    steady = 1'b0;
    directed = {
      step_load(ACT_LOAD_X, 12'd0, 16'h7FFF),
      step_load(ACT_LOAD_Y, 12'd0, 16'h8000),
      step_pair(12'd0, 12'd0, 1'b1, 46'd4294836225, 1'b0),
      step_load(ACT_LOAD_X, 12'hFFF, 16'h8000),
      step_load(ACT_LOAD_Y, 12'hFFF, 16'h8000),
      step_pair(12'hFFF, 12'hFFF, 1'b1, '0, 1'b0),
      step_pair(12'hFFF, 12'd0, 1'b0, '0, 1'b0),
      step_load(ACT_UNUSED, 12'hFFF, 16'hFFFF),
      step_load(ACT_LOAD_X, 12'd1, 16'hFFFF),
      step_load(ACT_LOAD_Y, 12'd1, 16'h0001),
      step_load(ACT_LOAD_X, 12'd2, 16'h3039),
      step_load(ACT_LOAD_Y, 12'd2, 16'hA460),
      step_load(ACT_LOAD_X, 12'd3, 16'h5555),
      step_load(ACT_LOAD_Y, 12'd3, 16'hAAAA),
      step_reg(CFG_WINDOW_LEN, 16'd2),
      step_reg(CFG_ROWS_IN_USE, 16'd2),
      step_pair(12'd0, 12'd0, 1'b0, '0, 1'b0),
      step_pair(12'd4093, 12'd0, 1'b1, '0, 1'b1),
      step_reg(CFG_WINDOW_LEN, 16'd0),
      step_reg(CFG_ROWS_IN_USE, 16'd3),
      step_pair(12'hFFF, 12'hFFF, 1'b1, '0, 1'b0),
      step_reg(CFG_ROWS_IN_USE, 16'd0),
      step_pair(12'hABC, 12'h543, 1'b1, '0, 1'b0),
      step_reg(CFG_WINDOW_LEN, 16'd1),
      step_reg(CFG_ROWS_IN_USE, 16'd65),
      step_pair(12'hFFF, 12'hFFF, 1'b1, '0, 1'b1),
      step_reg(4'hF, 16'hFFFF),
      step_reg(CFG_WINDOW_LEN, 16'hFFFF),
      step_reg(CFG_ROWS_IN_USE, 16'hFFFF),
      step_pair(12'd0, 12'd0, 1'b1, '0, 1'b1),
      step_reg(CFG_WINDOW_LEN, 16'h1000),
      step_reg(CFG_ROWS_IN_USE, 16'd1),
      step_pair(12'd0, 12'd1, 1'b1, '0, 1'b1)
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[s]) begin
      if (directed[s].is_reg) begin
        settle();
        write_reg(directed[s].reg_idx, directed[s].reg_val);
      end else begin
        drive_item(directed[s].item, directed[s].fixed, directed[s].sum, directed[s].err);
      end
    end

    // fill the low end of both stores, extremes on even addresses, then sum across it
    steady = 1'b1;
    it = '0;
    for (a = 0; a < FILL; a++) begin
      it.sample_addr = 12'(a);
      it.action = ACT_LOAD_X;
      it.sample_value = a[0] ? 16'($urandom) : 16'sh7FFF;
      drive_item(it, 1'b0, '0, 1'b0);
      it.action = ACT_LOAD_Y;
      it.sample_value = a[0] ? 16'($urandom) : 16'sh8000;
      drive_item(it, 1'b0, '0, 1'b0);
    end
    it = '0;
    it.action = ACT_COMPUTE;
    settle();
    write_reg(CFG_WINDOW_LEN, 16'(FILL));
    write_reg(CFG_ROWS_IN_USE, 16'd1);
    drive_item(it, 1'b0, '0, 1'b0);
    settle();
    write_reg(CFG_WINDOW_LEN, 16'd2);
    write_reg(CFG_ROWS_IN_USE, 16'(FILL / 2));
    drive_item(it, 1'b0, '0, 1'b0);

    for (a = 0; a < PHASES; a++) run_phase(a);
    settle();

    $display("Drove %0d items (%0d lag pairs) across %0d register writes;", n_items, n_pairs,
             n_writes);
    $display("checked %0d row sums, including windows over the filled region and out-of-range pairs.",
             n_checked);
    if (n_errors == 0 && pending_rows.size() == 0) begin
      $display("** lagged_squared_difference_sums: PASSED **");
    end else begin
      $display("** lagged_squared_difference_sums: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("** lagged_squared_difference_sums: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lsds_pkg.sv
rtl/core/lsds_front.sv
rtl/core/lsds_queue.sv
rtl/core/lsds_back.sv
rtl/core/lagged_squared_difference_sums.sv
bench/tb_lagged_squared_difference_sums.sv
